// ----- rtl/mfmc_pkg.sv -----
`timescale 1ns / 1ps
package mfmc_pkg;
	localparam int NV      = 16;
	localparam int VB      = 4;
	localparam int AW      = 2 * VB;
	localparam int ND      = NV * NV;
	localparam int CFG_W   = 5;
	localparam int CAP_W   = 16;
	localparam int RES_W   = 20;
	localparam int FLOW_W  = 20;
	localparam logic [FLOW_W-1:0] FLOW_LIMIT = '1;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_VCOUNT = 2'd0,
		REG_SOURCE = 2'd1,
		REG_SINK   = 2'd2,
		REG_NONE   = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BFS_INIT,
		ST_BFS_POP,
		ST_BFS_RD,
		ST_BFS_CHK,
		ST_PATH_RD,
		ST_PATH_CHK,
		ST_UPD_RD1,
		ST_UPD_WR1,
		ST_UPD_RD2,
		ST_UPD_WR2,
		ST_FIN
	} state_t;
endpackage

// ----- rtl/max_flow_min_cut.sv -----
`timescale 1ns / 1ps
// max flow / min cut engine over a residual capacity matrix
// input channel in_valid/in_ready carries cmd, from_vertex, to_vertex, capacity
// clear and load give no result; loads may stream back to back, one per
// cycle, while no run is in progress
// a run gives one result on out_valid/out_ready: total_flow, source_side, status
// a run repeats a search; per path found, each edge on it is read for the
// bottleneck, then both directions are read and written; a last state loads
// the result; the residual memory is read one entry per cycle
// in_ready is low while a run is in progress
// a finished result is held in the output register until taken; clears and
// loads are still taken meanwhile, a following run stalls at its end
// reset empties the matrix (per-entry valid bits, no clearing pass) and loads
// vertex_count 16, source 1, sink 16; config writes on cfg_we/cfg_index/
// cfg_data apply at once; the user must keep them to idle (not enforced)
module max_flow_min_cut (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         cmd,
	input  logic [4:0]                         from_vertex,
	input  logic [4:0]                         to_vertex,
	input  logic [mfmc_pkg::CAP_W-1:0]         capacity,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [mfmc_pkg::FLOW_W-1:0]        total_flow,
	output logic [mfmc_pkg::NV-1:0]            source_side,
	output logic                               status,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [mfmc_pkg::CFG_W-1:0]         cfg_data
);
	localparam int VB = mfmc_pkg::VB;
	localparam int NV = mfmc_pkg::NV;

	mfmc_pkg::state_t st_q, st_d;

	logic [mfmc_pkg::CFG_W-1:0] vcount_q, source_q, sink_q;
	logic [VB-1:0]              s0_q, t0_q, u_q, w_q;
	logic [VB:0]                n_q, v_q, head_q, tail_q;
	logic                       sink_ok_q;
	logic [NV-1:0]              mask_q;
	logic [VB-1:0]              pred_q [NV];
	logic [VB-1:0]              queue_q [NV];
	logic [mfmc_pkg::RES_W-1:0] bneck_q;
	logic [mfmc_pkg::FLOW_W-1:0] flow_q;
	logic                       err_q, pend_q;

	// residual memory with per-entry valid bits
	logic [mfmc_pkg::RES_W-1:0] mem [mfmc_pkg::ND];
	logic [mfmc_pkg::ND-1:0]    vld_q;
	logic [mfmc_pkg::AW-1:0]    rd_addr, wr_addr;
	logic                       wr_en, clr;
	logic [mfmc_pkg::RES_W-1:0] wr_data, rd_data_s1, rdval;
	logic                       rdv_s1;

	logic                       acc, run_acc, load_ok;
	logic [VB:0]                n_eff;
	logic [VB-1:0]              pred_w;
	logic [mfmc_pkg::FLOW_W:0]  flow_sum;

	assign acc      = in_valid && in_ready;
	assign in_ready = (st_q == mfmc_pkg::ST_IDLE);
	assign run_acc  = acc && (cmd == mfmc_pkg::CMD_RUN);
	assign load_ok  = (from_vertex >= 5'd1) && (from_vertex <= 5'(NV)) &&
		(to_vertex >= 5'd1) && (to_vertex <= 5'(NV));
	assign n_eff    = (vcount_q > 5'(NV)) ? (VB+1)'(NV) : (VB+1)'(vcount_q);
	assign pred_w   = pred_q[w_q];
	assign rdval    = rdv_s1 ? rd_data_s1 : '0;
	assign flow_sum = {1'b0, flow_q} + (mfmc_pkg::FLOW_W+1)'(bneck_q);

	always_comb begin
		st_d    = st_q;
		rd_addr = {u_q, v_q[VB-1:0]};
		wr_en   = 1'b0;
		clr     = 1'b0;
		wr_addr = {u_q, w_q};
		wr_data = rdval - bneck_q;
		case (st_q)
			mfmc_pkg::ST_IDLE: begin
				if (acc) begin
					case (cmd)
						mfmc_pkg::CMD_CLEAR: clr = 1'b1;
						mfmc_pkg::CMD_LOAD: begin
							wr_en   = load_ok;
							wr_addr = {from_vertex[VB-1:0] - 1'b1, to_vertex[VB-1:0] - 1'b1};
							wr_data = mfmc_pkg::RES_W'(capacity);
						end
						mfmc_pkg::CMD_RUN: begin
							if (source_q == sink_q || source_q < 5'd1 ||
								source_q > 5'(n_eff))
								st_d = mfmc_pkg::ST_FIN;
							else
								st_d = mfmc_pkg::ST_BFS_INIT;
						end
						default: ;
					endcase
				end
			end
			mfmc_pkg::ST_BFS_INIT: st_d = mfmc_pkg::ST_BFS_POP;
			mfmc_pkg::ST_BFS_POP: begin
				if (head_q < tail_q)
					st_d = mfmc_pkg::ST_BFS_RD;
				else if (sink_ok_q && mask_q[t0_q])
					st_d = mfmc_pkg::ST_PATH_RD;
				else
					st_d = mfmc_pkg::ST_FIN;
			end
			mfmc_pkg::ST_BFS_RD: st_d = mfmc_pkg::ST_BFS_CHK;
			mfmc_pkg::ST_BFS_CHK: begin
				if (v_q + 1'b1 >= n_q)
					st_d = mfmc_pkg::ST_BFS_POP;
				else
					st_d = mfmc_pkg::ST_BFS_RD;
			end
			mfmc_pkg::ST_PATH_RD: begin
				rd_addr = {pred_w, w_q};
				st_d    = mfmc_pkg::ST_PATH_CHK;
			end
			mfmc_pkg::ST_PATH_CHK: begin
				if (u_q == s0_q)
					st_d = mfmc_pkg::ST_UPD_RD1;
				else
					st_d = mfmc_pkg::ST_PATH_RD;
			end
			mfmc_pkg::ST_UPD_RD1: begin
				rd_addr = {pred_w, w_q};
				st_d    = mfmc_pkg::ST_UPD_WR1;
			end
			mfmc_pkg::ST_UPD_WR1: begin
				wr_en = 1'b1;
				st_d  = mfmc_pkg::ST_UPD_RD2;
			end
			mfmc_pkg::ST_UPD_RD2: begin
				rd_addr = {w_q, u_q};
				st_d    = mfmc_pkg::ST_UPD_WR2;
			end
			mfmc_pkg::ST_UPD_WR2: begin
				wr_en   = 1'b1;
				wr_addr = {w_q, u_q};
				wr_data = rdval + bneck_q;
				if (u_q == s0_q)
					st_d = mfmc_pkg::ST_BFS_INIT;
				else
					st_d = mfmc_pkg::ST_UPD_RD1;
			end
			mfmc_pkg::ST_FIN: begin
				if (!pend_q || out_ready)
					st_d = mfmc_pkg::ST_IDLE;
			end
			default: st_d = mfmc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= mfmc_pkg::ST_IDLE;
		else
			st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[rd_addr];
		rdv_s1     <= vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (clr)
			vld_q <= '0;
		else if (wr_en)
			vld_q[wr_addr] <= 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= mfmc_pkg::CFG_W'(16);
			source_q <= mfmc_pkg::CFG_W'(1);
			sink_q   <= mfmc_pkg::CFG_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				mfmc_pkg::REG_VCOUNT: vcount_q <= cfg_data;
				mfmc_pkg::REG_SOURCE: source_q <= cfg_data;
				mfmc_pkg::REG_SINK:   sink_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// search and path datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			flow_q    <= '0;
			bneck_q   <= '0;
			err_q     <= 1'b0;
			n_q       <= '0;
			v_q       <= '0;
			s0_q      <= '0;
			t0_q      <= '0;
			u_q       <= '0;
			w_q       <= '0;
			sink_ok_q <= 1'b0;
			pred_q    <= '{default: '0};
			queue_q   <= '{default: '0};
		end else begin
			case (st_q)
				mfmc_pkg::ST_IDLE: begin
					if (run_acc) begin
						n_q       <= n_eff;
						s0_q      <= VB'(source_q - 1'b1);
						t0_q      <= VB'(sink_q - 1'b1);
						sink_ok_q <= (sink_q >= 5'd1) && (sink_q <= 5'(n_eff));
						err_q     <= (source_q == sink_q);
						flow_q    <= '0;
						mask_q    <= '0;
					end
				end
				mfmc_pkg::ST_BFS_INIT: begin
					mask_q        <= NV'(1) << s0_q;
					pred_q[s0_q]  <= s0_q;
					queue_q[0]    <= s0_q;
					head_q        <= '0;
					tail_q        <= (VB+1)'(1);
				end
				mfmc_pkg::ST_BFS_POP: begin
					if (head_q < tail_q) begin
						u_q    <= queue_q[head_q[VB-1:0]];
						head_q <= head_q + 1'b1;
						v_q    <= '0;
					end else begin
						w_q     <= t0_q;
						bneck_q <= '1;
					end
				end
				mfmc_pkg::ST_BFS_CHK: begin
					if (!mask_q[v_q[VB-1:0]] && rdval != '0) begin
						mask_q[v_q[VB-1:0]]    <= 1'b1;
						pred_q[v_q[VB-1:0]]    <= u_q;
						queue_q[tail_q[VB-1:0]] <= v_q[VB-1:0];
						tail_q                 <= tail_q + 1'b1;
					end
					v_q <= v_q + 1'b1;
				end
				mfmc_pkg::ST_PATH_RD: u_q <= pred_w;
				mfmc_pkg::ST_PATH_CHK: begin
					if (rdval < bneck_q)
						bneck_q <= rdval;
					w_q <= (u_q == s0_q) ? t0_q : u_q;
				end
				mfmc_pkg::ST_UPD_RD1: u_q <= pred_w;
				mfmc_pkg::ST_UPD_WR2: begin
					w_q <= u_q;
					if (u_q == s0_q)
						flow_q <= flow_sum[mfmc_pkg::FLOW_W] ? mfmc_pkg::FLOW_LIMIT :
							flow_sum[mfmc_pkg::FLOW_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			total_flow  <= '0;
			source_side <= '0;
			status      <= 1'b0;
		end else if (st_q == mfmc_pkg::ST_FIN && (!pend_q || out_ready)) begin
			pend_q      <= 1'b1;
			total_flow  <= flow_q;
			source_side <= mask_q;
			status      <= err_q;
		end else if (out_ready) begin
			pend_q <= 1'b0;
		end
	end

	assign out_valid = pend_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> total_flow == '0 && source_side == '0)
		else $error("error status with nonzero result");
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q && tail_q <= (VB+1)'(NV))
		else $error("search queue pointers out of order");
	a_src_reached: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == mfmc_pkg::ST_BFS_POP |-> mask_q[s0_q])
		else $error("source not marked during search");
`endif
endmodule

// ----- tb/max_flow_min_cut_test.sv -----
`timescale 1ns / 1ps
module max_flow_min_cut_test;

	typedef struct {
		logic [mfmc_pkg::FLOW_W-1:0] flow;
		logic [mfmc_pkg::NV-1:0]     side;
		logic                        err;
	} flow_result_t;

	class flow_scoreboard;
		logic [19:0] resid [mfmc_pkg::NV*mfmc_pkg::NV];
		logic [3:0]  pred [mfmc_pkg::NV];
		logic [4:0]  vcount, src, snk;
		flow_result_t awaited [$];
		int errors;

		function new();
			foreach (resid[i]) resid[i] = '0;
			vcount = 5'd16;
			src = 5'd1;
			snk = 5'd16;
			errors = 0;
		endfunction

		function void set_reg(mfmc_pkg::cfg_reg_t idx, logic [4:0] val);
			case (idx)
				mfmc_pkg::REG_VCOUNT: vcount = val;
				mfmc_pkg::REG_SOURCE: src = val;
				mfmc_pkg::REG_SINK: snk = val;
				default: ;
			endcase
		endfunction

		// breadth-first reach over the residual graph, neighbours in ascending order
		function logic [mfmc_pkg::NV-1:0] reach(int s0, int n);
			logic [mfmc_pkg::NV-1:0] mask;
			int q [$];
			int u;
			mask = '0;
			mask[s0] = 1'b1;
			pred[s0] = 4'(s0);
			q.push_back(s0);
			while (q.size() > 0) begin
				u = q.pop_front();
				for (int v = 0; v < n; v++) begin
					if (!mask[v] && resid[u*mfmc_pkg::NV+v] != 0) begin
						mask[v] = 1'b1;
						pred[v] = 4'(u);
						q.push_back(v);
					end
				end
			end
			return mask;
		endfunction

		function void note(logic [1:0] c, logic [4:0] f, logic [4:0] t, logic [15:0] cap);
			flow_result_t r;
			int n, s0, t0, u, v;
			logic [19:0] neck;
			int sum;
			logic [mfmc_pkg::NV-1:0] mask;
			case (c)
				mfmc_pkg::CMD_CLEAR: foreach (resid[i]) resid[i] = '0;
				mfmc_pkg::CMD_LOAD:
					if (f >= 1 && f <= mfmc_pkg::NV && t >= 1 && t <= mfmc_pkg::NV)
						resid[(f-1)*mfmc_pkg::NV + (t-1)] = 20'(cap);
				mfmc_pkg::CMD_RUN: begin
					r.flow = '0;
					r.side = '0;
					r.err = 1'b0;
					if (src == snk) begin
						r.err = 1'b1;
					end else begin
						n = vcount > mfmc_pkg::NV ? mfmc_pkg::NV : vcount;
						if (src >= 1 && src <= n) begin
							s0 = src - 1;
							t0 = snk - 1;
							sum = 0;
							forever begin
								mask = reach(s0, n);
								if (!(snk >= 1 && snk <= n) || !mask[t0]) break;
								neck = '1;
								for (v = t0; v != s0; v = u) begin
									u = pred[v];
									if (resid[u*mfmc_pkg::NV+v] < neck)
										neck = resid[u*mfmc_pkg::NV+v];
								end
								for (v = t0; v != s0; v = u) begin
									u = pred[v];
									resid[u*mfmc_pkg::NV+v] -= neck;
									resid[v*mfmc_pkg::NV+u] += neck;
								end
								sum += neck;
								if (sum > mfmc_pkg::FLOW_LIMIT) sum = mfmc_pkg::FLOW_LIMIT;
							end
							r.flow = 20'(sum);
							r.side = mask;
						end
					end
					awaited.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check(logic [mfmc_pkg::FLOW_W-1:0] flow, logic [mfmc_pkg::NV-1:0] side,
			logic err);
			flow_result_t e;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result flow %0d side %h status %0d",
					$time, flow, side, err);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (flow !== e.flow) begin
				$display("%0t: total_flow expected %0d actual %0d", $time, e.flow, flow);
				errors++;
			end
			if (side !== e.side) begin
				$display("%0t: source_side expected %h actual %h", $time, e.side, side);
				errors++;
			end
			if (err !== e.err) begin
				$display("%0t: status expected %0d actual %0d", $time, e.err, err);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] cmd;
	logic [4:0] from_vertex, to_vertex;
	logic [mfmc_pkg::CAP_W-1:0] capacity;
	logic [mfmc_pkg::FLOW_W-1:0] total_flow;
	logic [mfmc_pkg::NV-1:0] source_side;
	logic status;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [mfmc_pkg::CFG_W-1:0] cfg_data;

	flow_scoreboard sb = new();
	int sent = 0;
	bit quiet = 0;
	bit hold_req = 0;

	max_flow_min_cut uut (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cmd = mfmc_pkg::CMD_NOP;
		from_vertex = '0;
		to_vertex = '0;
		capacity = '0;
		cfg_we = 1'b0;
		cfg_index = mfmc_pkg::REG_NONE;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic send(logic [1:0] c, logic [4:0] f, logic [4:0] t, logic [15:0] cap);
		int gap;
		in_valid <= 1'b1;
		cmd <= c;
		from_vertex <= f;
		to_vertex <= t;
		capacity <= cap;
		do @(posedge clk); while (!in_ready);
		sb.note(c, f, t, cap);
		sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cfg(logic [4:0] vc, logic [4:0] s, logic [4:0] t);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= mfmc_pkg::REG_VCOUNT; cfg_data <= vc; @(posedge clk);
		cfg_index <= mfmc_pkg::REG_SOURCE; cfg_data <= s; @(posedge clk);
		cfg_index <= mfmc_pkg::REG_SINK; cfg_data <= t; @(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(mfmc_pkg::REG_VCOUNT, vc);
		sb.set_reg(mfmc_pkg::REG_SOURCE, s);
		sb.set_reg(mfmc_pkg::REG_SINK, t);
	endtask

	function automatic logic [15:0] rand_cap();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 9));
			default: return 16'($urandom());
		endcase
	endfunction

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check(total_flow, source_side, status);

	// receiver side: random backpressure, one long hold on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int n, k, ph;
		logic [4:0] vc, s, t;
		@(posedge arst_n);
		@(posedge clk);
		// directed: defaults on empty graph, extreme edges, ignored items
		send(mfmc_pkg::CMD_RUN, 0, 0, 0);
		send(mfmc_pkg::CMD_LOAD, 1, 16, 16'hFFFF);
		send(mfmc_pkg::CMD_LOAD, 1, 2, 16'd0);
		send(mfmc_pkg::CMD_LOAD, 0, 5, 16'h1234);
		send(mfmc_pkg::CMD_LOAD, 17, 31, 16'hAAAA);
		send(mfmc_pkg::CMD_LOAD, 16, 0, 16'h5555);
		send(mfmc_pkg::CMD_NOP, 31, 31, 16'hFFFF);
		send(mfmc_pkg::CMD_RUN, 0, 0, 0);
		send(mfmc_pkg::CMD_RUN, 0, 0, 0);
		send(mfmc_pkg::CMD_LOAD, 1, 16, 16'd7);
		send(mfmc_pkg::CMD_RUN, 0, 0, 0);
		write_cfg(5'd16, 5'd3, 5'd3);
		send(mfmc_pkg::CMD_RUN, 0, 0, 0);
		write_cfg(5'd31, 5'd1, 5'd16);
		send(mfmc_pkg::CMD_CLEAR, 0, 0, 0);
		send(mfmc_pkg::CMD_LOAD, 1, 8, 16'd100);
		send(mfmc_pkg::CMD_LOAD, 8, 16, 16'd60);
		send(mfmc_pkg::CMD_RUN, 0, 0, 0);
		write_cfg(5'd1, 5'd1, 5'd2);
		send(mfmc_pkg::CMD_RUN, 0, 0, 0);
		write_cfg(5'd0, 5'd0, 5'd31);
		send(mfmc_pkg::CMD_RUN, 0, 0, 0);
		write_cfg(5'd8, 5'd2, 5'd31);
		send(mfmc_pkg::CMD_RUN, 0, 0, 0);
		write_cfg(5'd2, 5'd2, 5'd1);
		send(mfmc_pkg::CMD_LOAD, 2, 1, 16'd9);
		send(mfmc_pkg::CMD_RUN, 0, 0, 0);

		ph = 0;
		while (sent < 1850) begin
			if (sent > 1650) quiet = 1;
			if ($urandom_range(0, 9) == 0) vc = 5'd16;
			else if ($urandom_range(0, 14) == 0) vc = 5'($urandom_range(0, 31));
			else vc = 5'($urandom_range(2, 6));
			n = vc > 16 ? 16 : (vc < 2 ? 2 : vc);
			if ($urandom_range(0, 9) == 0) begin
				s = 5'($urandom_range(0, 31));
				t = 5'($urandom_range(0, 31));
			end else begin
				s = 5'($urandom_range(1, n));
				t = 5'($urandom_range(1, n));
				if (s == t && $urandom_range(0, 3) != 0) t = 5'((s % n) + 1);
			end
			write_cfg(vc, s, t);
			if (ph % 7 == 3) drain();
			send(mfmc_pkg::CMD_CLEAR, 5'($urandom()), 5'($urandom()), 16'($urandom()));
			k = $urandom_range(1, 3 * n);
			repeat (k) begin
				case ($urandom_range(0, 14))
					0: send(mfmc_pkg::CMD_LOAD, 5'($urandom()), 5'($urandom()),
						16'($urandom()));
					1: send(mfmc_pkg::CMD_NOP, 5'($urandom()), 5'($urandom()),
						16'($urandom()));
					default: send(mfmc_pkg::CMD_LOAD, 5'($urandom_range(1, n)),
						5'($urandom_range(1, n)), rand_cap());
				endcase
			end
			send(mfmc_pkg::CMD_RUN, 5'($urandom()), 5'($urandom()), 16'($urandom()));
			if (ph == 5 || ph == 40) begin
				// long output stall while loads keep coming; the next run must wait
				hold_req = 1;
				repeat (10) send(mfmc_pkg::CMD_LOAD, 5'($urandom_range(1, n)),
					5'($urandom_range(1, n)), rand_cap());
				send(mfmc_pkg::CMD_RUN, 0, 0, 0);
				repeat (6) send(mfmc_pkg::CMD_LOAD, 5'($urandom_range(1, n)),
					5'($urandom_range(1, n)), rand_cap());
			end
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(0, 2))
					send(mfmc_pkg::CMD_LOAD, 5'($urandom_range(1, n)),
						5'($urandom_range(1, n)), rand_cap());
				send(mfmc_pkg::CMD_RUN, 5'($urandom()), 5'($urandom()), 16'($urandom()));
			end
			ph++;
		end
		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/mfmc_pkg.sv
rtl/max_flow_min_cut.sv
tb/max_flow_min_cut_test.sv
